// ===== design/dataflash_sector_sequencer_assert.svh =====
// Assertion macros shared by the sector sequencer RTL.
// Expects clk_i and rst_ni in the scope where a macro is used.
`ifndef DATAFLASH_SECTOR_SEQUENCER_ASSERT_SVH
`define DATAFLASH_SECTOR_SEQUENCER_ASSERT_SVH

// Clocked property, checked outside reset.
`define DSS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Implication checked in the same cycle.
`define DSS_ASSERT_IMP(lbl, ante, cons, msg) \
  `DSS_ASSERT(lbl, (ante) |-> (cons), msg)

// Implication checked in the next cycle.
`define DSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  `DSS_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

// ===== design/dss_pkg.sv =====
// Types, command codes and byte helpers for the DataFlash sector sequencer.
// No dependencies.
`default_nettype none

package dss_pkg;

  localparam int SECTOR_BYTES = 512;
  localparam int SECTOR_COUNT = 16384;

  localparam int SectorW = 14;
  localparam int CountW  = 10;
  localparam int NextW   = CountW + 1;

  // Last index values of the buffer frames (index of next byte)
  localparam logic [NextW-1:0] RD_END = NextW'(5 + SECTOR_BYTES);
  localparam logic [NextW-1:0] WR_END = NextW'(4 + SECTOR_BYTES);
  localparam logic [23:0]      ODD_OFFSET = 24'(SECTOR_BYTES);

  // Command codes
  localparam logic [2:0] CMD_XFER  = 3'd0;
  localparam logic [2:0] CMD_READ  = 3'd1;
  localparam logic [2:0] CMD_WRITE = 3'd2;
  localparam logic [2:0] CMD_MEDIA = 3'd3;
  localparam logic [2:0] CMD_WAIT  = 3'd4;

  // Flash opcodes and masks
  localparam logic [7:0] OPC_LOAD   = 8'h53;
  localparam logic [7:0] OPC_ERASE  = 8'h81;
  localparam logic [7:0] OPC_WRBUF  = 8'h84;
  localparam logic [7:0] OPC_PROG   = 8'h88;
  localparam logic [7:0] OPC_RDBUF  = 8'hD4;
  localparam logic [7:0] OPC_STATUS = 8'hD7;
  localparam logic [7:0] BYTE_FILL  = 8'hFF;
  localparam logic [7:0] MEDIA_MASK = 8'hBF;
  localparam logic [7:0] MEDIA_PAT  = 8'hBC;

  typedef enum logic [4:0] {
    OP_IDLE  = 5'b00001,
    OP_READ  = 5'b00010,
    OP_WRITE = 5'b00100,
    OP_MEDIA = 5'b01000,
    OP_WAIT  = 5'b10000
  } op_e;

  typedef enum logic [9:0] {
    PH_LOAD       = 10'b0000000001,
    PH_POLL_LOAD  = 10'b0000000010,
    PH_RDBUF      = 10'b0000000100,
    PH_ERASE      = 10'b0000001000,
    PH_POLL_ERASE = 10'b0000010000,
    PH_WRBUF      = 10'b0000100000,
    PH_PROG       = 10'b0001000000,
    PH_POLL_PROG  = 10'b0010000000,
    PH_STATUS     = 10'b0100000000,
    PH_POLL_IDLE  = 10'b1000000000
  } phase_e;

  typedef struct packed {
    logic       tx_valid;
    logic [7:0] tx_byte;
    logic       frame_first;
    logic       rd_valid;
    logic [7:0] rd_byte;
    logic       wr_taken;
    logic       done_res;
    logic       media_ok;
    logic       rejected;
  } res_t;

  // Byte k (1 = most significant) of the 24-bit page address
  function automatic logic [7:0] addr_byte(logic [SectorW-1:0] sec, logic [1:0] k);
    logic [23:0] a;
    a = {sec, 10'b0};
    case (k)
      2'd1:    addr_byte = a[23:16];
      2'd2:    addr_byte = a[15:8];
      default: addr_byte = a[7:0];
    endcase
  endfunction

  // Byte k of the buffer offset: odd sectors sit in the upper half
  function automatic logic [7:0] off_byte(logic odd, logic [1:0] k);
    logic [23:0] o;
    o = odd ? ODD_OFFSET : 24'd0;
    case (k)
      2'd1:    off_byte = o[23:16];
      2'd2:    off_byte = o[15:8];
      default: off_byte = o[7:0];
    endcase
  endfunction

endpackage

`default_nettype wire

// ===== design/dss_core.sv =====
// Sequencer state and next-byte logic: one item per step.
// Depends on dss_pkg and dataflash_sector_sequencer_assert.svh.
`default_nettype none
`include "dataflash_sector_sequencer_assert.svh"

module dss_core import dss_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               step_i,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [SectorW-1:0] sector_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic [7:0]         wr_byte_i,
  output res_t                    res_o
);

  op_e                op_q, op_d;
  phase_e             ph_q, ph_d;
  logic [CountW-1:0]  cnt_q, cnt_d;
  logic [SectorW-1:0] sec_q, sec_d;

  logic               busy;
  logic [NextW-1:0]   nx;
  logic               frm, snd, fin;
  phase_e             frm_ph;
  logic [7:0]         frm_byte, snd_byte;
  res_t               res;

  always_comb begin
    op_d     = op_q;
    ph_d     = ph_q;
    cnt_d    = cnt_q;
    sec_d    = sec_q;
    res      = '0;
    frm      = 1'b0;
    snd      = 1'b0;
    fin      = 1'b0;
    frm_ph   = ph_q;
    frm_byte = '0;
    snd_byte = '0;
    busy     = (op_q != OP_IDLE);
    nx       = {1'b0, cnt_q} + NextW'(1);

    if (cmd_i > CMD_WAIT || (cmd_i == CMD_XFER && !busy) ||
        (cmd_i != CMD_XFER && busy)) begin
      res.rejected = 1'b1;
    end else begin
      case (cmd_i)
        CMD_XFER: begin
          case (ph_q)
            PH_LOAD, PH_ERASE, PH_PROG: begin
              if (cnt_q < CountW'(3)) begin
                snd      = 1'b1;
                snd_byte = addr_byte(sec_q, nx[1:0]);
              end else begin
                frm      = 1'b1;
                frm_byte = OPC_STATUS;
                frm_ph   = (ph_q == PH_LOAD)  ? PH_POLL_LOAD :
                           (ph_q == PH_ERASE) ? PH_POLL_ERASE : PH_POLL_PROG;
              end
            end
            PH_POLL_LOAD, PH_POLL_ERASE, PH_POLL_PROG, PH_POLL_IDLE, PH_STATUS: begin
              if (cnt_q == '0) begin
                snd      = 1'b1;
                snd_byte = BYTE_FILL;
              end else if (ph_q == PH_STATUS) begin
                res.media_ok = ((rx_byte_i & MEDIA_MASK) == MEDIA_PAT);
                fin          = 1'b1;
              end else if (!rx_byte_i[7]) begin
                // chip still busy: poll again
                frm      = 1'b1;
                frm_byte = OPC_STATUS;
              end else if (ph_q == PH_POLL_LOAD) begin
                frm      = 1'b1;
                frm_ph   = (op_q == OP_WRITE) ? PH_ERASE : PH_RDBUF;
                frm_byte = (op_q == OP_WRITE) ? OPC_ERASE : OPC_RDBUF;
              end else if (ph_q == PH_POLL_ERASE) begin
                frm      = 1'b1;
                frm_ph   = PH_WRBUF;
                frm_byte = OPC_WRBUF;
              end else begin
                fin = 1'b1;
              end
            end
            PH_RDBUF: begin
              if (cnt_q >= CountW'(5)) begin
                res.rd_valid = 1'b1;
                res.rd_byte  = rx_byte_i;
              end
              if (nx <= NextW'(3)) begin
                snd      = 1'b1;
                snd_byte = off_byte(sec_q[0], nx[1:0]);
              end else if (nx < RD_END) begin
                snd = 1'b1;
              end else begin
                fin = 1'b1;
              end
            end
            PH_WRBUF: begin
              if (nx <= NextW'(3)) begin
                snd      = 1'b1;
                snd_byte = off_byte(sec_q[0], nx[1:0]);
              end else if (nx < WR_END) begin
                snd          = 1'b1;
                snd_byte     = wr_byte_i;
                res.wr_taken = 1'b1;
              end else begin
                frm      = 1'b1;
                frm_ph   = PH_PROG;
                frm_byte = OPC_PROG;
              end
            end
            default: fin = 1'b1;
          endcase
        end
        CMD_READ, CMD_WRITE: begin
          sec_d    = SectorW'(sector_i % SECTOR_COUNT);
          op_d     = (cmd_i == CMD_READ) ? OP_READ : OP_WRITE;
          frm      = 1'b1;
          frm_ph   = PH_LOAD;
          frm_byte = OPC_LOAD;
        end
        CMD_MEDIA: begin
          op_d     = OP_MEDIA;
          frm      = 1'b1;
          frm_ph   = PH_STATUS;
          frm_byte = OPC_STATUS;
        end
        default: begin
          op_d     = OP_WAIT;
          frm      = 1'b1;
          frm_ph   = PH_POLL_IDLE;
          frm_byte = OPC_STATUS;
        end
      endcase
    end

    if (frm) begin
      ph_d            = frm_ph;
      cnt_d           = '0;
      res.tx_valid    = 1'b1;
      res.tx_byte     = frm_byte;
      res.frame_first = 1'b1;
    end
    if (snd) begin
      cnt_d        = nx[CountW-1:0];
      res.tx_valid = 1'b1;
      res.tx_byte  = snd_byte;
    end
    if (fin) begin
      op_d         = OP_IDLE;
      ph_d         = PH_LOAD;
      cnt_d        = '0;
      res.done_res = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q  <= OP_IDLE;
      ph_q  <= PH_LOAD;
      cnt_q <= '0;
      sec_q <= '0;
    end else if (step_i) begin
      op_q  <= op_d;
      ph_q  <= ph_d;
      cnt_q <= cnt_d;
      sec_q <= sec_d;
    end
  end

  assign res_o = res;

  `DSS_ASSERT_IMP(a_one_outcome, step_i, $onehot({res.tx_valid, res.done_res, res.rejected}),
    "step must give exactly one of send, done, reject")
  `DSS_ASSERT_IMP(a_wr_only_writing, step_i && res.wr_taken,
    op_q == OP_WRITE && ph_q == PH_WRBUF && res.tx_byte == wr_byte_i,
    "host byte taken outside write-buffer phase")
  `DSS_ASSERT_NEXT(a_done_idle, step_i && res.done_res, op_q == OP_IDLE && cnt_q == '0,
    "sequencer not idle after done")
  `DSS_ASSERT_IMP(a_idle_count, op_q == OP_IDLE, cnt_q == '0 && ph_q == PH_LOAD,
    "idle sequencer holds stale phase or count")

endmodule

`default_nettype wire

// ===== design/dataflash_sector_sequencer.sv =====
// An accepted item enters the input register, which feeds the sequencing logic;
// the logic loads the result register once that register is free.
// Throughput: one item per cycle; the only limit is the result register
// draining to the consumer.
// Reset (rst_ni low, asynchronous): sequencer idle, both registers empty.
// Depends on dss_pkg, dss_core and dataflash_sector_sequencer_assert.svh.
`default_nettype none
`include "dataflash_sector_sequencer_assert.svh"

module dataflash_sector_sequencer import dss_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output      logic               in_ready_o,
  input  wire logic [2:0]         cmd_i,
  input  wire logic [SectorW-1:0] sector_i,
  input  wire logic [7:0]         rx_byte_i,
  input  wire logic [7:0]         wr_byte_i,
  output      logic               out_valid_o,
  input  wire logic               out_ready_i,
  output      logic               tx_valid_o,
  output      logic [7:0]         tx_byte_o,
  output      logic               frame_first_o,
  output      logic               rd_valid_o,
  output      logic [7:0]         rd_byte_o,
  output      logic               wr_taken_o,
  output      logic               done_res_o,
  output      logic               media_ok_o,
  output      logic               rejected_o
);

  logic               in_valid_q;
  logic [2:0]         cmd_q;
  logic [SectorW-1:0] sector_q;
  logic [7:0]         rx_q, wr_q;
  logic               out_valid_q;
  res_t               res_q;
  res_t               res;
  logic               out_free, step;

  assign out_free   = !out_valid_q || out_ready_i;
  assign step       = in_valid_q && out_free;
  assign in_ready_o = !in_valid_q || step;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (out_free) begin
        out_valid_q <= step;
      end
    end
  end

  // payload registers load on accept, the result register on step; hold otherwise
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      cmd_q    <= cmd_i;
      sector_q <= sector_i;
      rx_q     <= rx_byte_i;
      wr_q     <= wr_byte_i;
    end
    if (step) begin
      res_q <= res;
    end
  end

  dss_core u_core (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .step_i    (step),
    .cmd_i     (cmd_q),
    .sector_i  (sector_q),
    .rx_byte_i (rx_q),
    .wr_byte_i (wr_q),
    .res_o     (res)
  );

  assign out_valid_o   = out_valid_q;
  assign tx_valid_o    = res_q.tx_valid;
  assign tx_byte_o     = res_q.tx_byte;
  assign frame_first_o = res_q.frame_first;
  assign rd_valid_o    = res_q.rd_valid;
  assign rd_byte_o     = res_q.rd_byte;
  assign wr_taken_o    = res_q.wr_taken;
  assign done_res_o    = res_q.done_res;
  assign media_ok_o    = res_q.media_ok;
  assign rejected_o    = res_q.rejected;

  `DSS_ASSERT_NEXT(a_result_held, out_valid_q && !out_ready_i,
    out_valid_q && $stable(res_q), "stalled result changed")
  `DSS_ASSERT_NEXT(a_step_fills, step, out_valid_q, "stepped item produced no result")
  `DSS_ASSERT_IMP(a_first_sends, out_valid_q && frame_first_o, tx_valid_o,
    "frame start without a byte to send")

endmodule

`default_nettype wire

// ===== sim/dataflash_sector_checker.sv =====
// Watches both item channels of the DataFlash sector sequencer, predicts each result
// from a cycle-free model of the sequencing rules, and compares results field by field.
// Depends on dss_pkg for command codes, opcodes, state enums and the result struct.
module dataflash_sector_checker import dss_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [2:0]         cmd_i,
  input  logic [SectorW-1:0] sector_i,
  input  logic [7:0]         rx_byte_i,
  input  logic [7:0]         wr_byte_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic               tx_valid_i,
  input  logic [7:0]         tx_byte_i,
  input  logic               frame_first_i,
  input  logic               rd_valid_i,
  input  logic [7:0]         rd_byte_i,
  input  logic               wr_taken_i,
  input  logic               done_res_i,
  input  logic               media_ok_i,
  input  logic               rejected_i,
  output int                 errors_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 data_bytes_o,
  output int                 rejects_o
);
  timeunit 1ns;
  timeprecision 1ps;

  op_e                cur_op;
  phase_e             cur_phase;
  logic [CountW-1:0]  xfer_idx;
  logic [SectorW-1:0] page_sector;
  res_t               expected_q[$];
  int                 fails;
  int                 results;
  int                 data_bytes;
  int                 rejects;

  // Byte k (1 = most significant) of the 24-bit page address
  function automatic logic [7:0] page_byte(int k);
    logic [23:0] a;
    a = {page_sector, 10'b0};
    return a[8*(3-k) +: 8];
  endfunction

  // Byte k of the buffer offset: odd sectors use the upper half of the buffer
  function automatic logic [7:0] buf_offset_byte(int k);
    logic [23:0] o;
    o = page_sector[0] ? 24'(SECTOR_BYTES) : 24'd0;
    return o[8*(3-k) +: 8];
  endfunction

  function automatic void open_frame(phase_e ph, logic [7:0] b, inout res_t r);
    cur_phase = ph;
    xfer_idx = '0;
    r.tx_valid = 1'b1;
    r.tx_byte = b;
    r.frame_first = 1'b1;
  endfunction

  function automatic void shift_next(logic [7:0] b, inout res_t r);
    xfer_idx = xfer_idx + 1'b1;
    r.tx_valid = 1'b1;
    r.tx_byte = b;
  endfunction

  function automatic void finish_op(inout res_t r);
    cur_op = OP_IDLE;
    cur_phase = PH_LOAD;
    xfer_idx = '0;
    r.done_res = 1'b1;
  endfunction

  function automatic res_t next_exchange(logic [2:0] cmd, logic [SectorW-1:0] sec,
                                         logic [7:0] rx, logic [7:0] wr);
    res_t r;
    bit   busy;
    int   idx;
    int   nx;
    r = '0;
    busy = (cur_op != OP_IDLE);
    idx = int'(xfer_idx);
    nx = idx + 1;
    if (cmd > CMD_WAIT || (cmd == CMD_XFER && !busy) || (cmd != CMD_XFER && busy)) begin
      r.rejected = 1'b1;
    end else if (cmd == CMD_XFER) begin
      case (cur_phase)
        PH_LOAD, PH_ERASE, PH_PROG: begin
          if (idx < 3) shift_next(page_byte(nx), r);
          else if (cur_phase == PH_LOAD) open_frame(PH_POLL_LOAD, OPC_STATUS, r);
          else if (cur_phase == PH_ERASE) open_frame(PH_POLL_ERASE, OPC_STATUS, r);
          else open_frame(PH_POLL_PROG, OPC_STATUS, r);
        end
        PH_POLL_LOAD, PH_POLL_ERASE, PH_POLL_PROG, PH_POLL_IDLE, PH_STATUS: begin
          if (idx == 0) begin
            shift_next(BYTE_FILL, r);
          end else if (cur_phase == PH_STATUS) begin
            r.media_ok = ((rx & MEDIA_MASK) == MEDIA_PAT);
            finish_op(r);
          end else if (!rx[7]) begin
            // chip still busy: poll again in a fresh frame
            open_frame(cur_phase, OPC_STATUS, r);
          end else if (cur_phase == PH_POLL_LOAD) begin
            if (cur_op == OP_WRITE) open_frame(PH_ERASE, OPC_ERASE, r);
            else open_frame(PH_RDBUF, OPC_RDBUF, r);
          end else if (cur_phase == PH_POLL_ERASE) begin
            open_frame(PH_WRBUF, OPC_WRBUF, r);
          end else begin
            finish_op(r);
          end
        end
        PH_RDBUF: begin
          // opcode, three offset bytes and a dummy come before the data
          if (idx >= 5) begin
            r.rd_valid = 1'b1;
            r.rd_byte = rx;
          end
          if (nx <= 3) shift_next(buf_offset_byte(nx), r);
          else if (nx < 5 + SECTOR_BYTES) shift_next(8'h00, r);
          else finish_op(r);
        end
        PH_WRBUF: begin
          if (nx <= 3) begin
            shift_next(buf_offset_byte(nx), r);
          end else if (nx < 4 + SECTOR_BYTES) begin
            shift_next(wr, r);
            r.wr_taken = 1'b1;
          end else begin
            open_frame(PH_PROG, OPC_PROG, r);
          end
        end
        default: finish_op(r);
      endcase
    end else begin
      case (cmd)
        CMD_READ, CMD_WRITE: begin
          page_sector = sec;
          cur_op = (cmd == CMD_READ) ? OP_READ : OP_WRITE;
          open_frame(PH_LOAD, OPC_LOAD, r);
        end
        CMD_MEDIA: begin
          cur_op = OP_MEDIA;
          open_frame(PH_STATUS, OPC_STATUS, r);
        end
        default: begin
          cur_op = OP_WAIT;
          open_frame(PH_POLL_IDLE, OPC_STATUS, r);
        end
      endcase
    end
    return r;
  endfunction

  function automatic string field_diffs(res_t e, res_t g);
    string s;
    s = "";
    if (e.tx_valid !== g.tx_valid)
      s = {s, $sformatf(" tx_valid exp %0b got %0b", e.tx_valid, g.tx_valid)};
    if (e.tx_byte !== g.tx_byte)
      s = {s, $sformatf(" tx_byte exp %02h got %02h", e.tx_byte, g.tx_byte)};
    if (e.frame_first !== g.frame_first)
      s = {s, $sformatf(" frame_first exp %0b got %0b", e.frame_first, g.frame_first)};
    if (e.rd_valid !== g.rd_valid)
      s = {s, $sformatf(" rd_valid exp %0b got %0b", e.rd_valid, g.rd_valid)};
    if (e.rd_byte !== g.rd_byte)
      s = {s, $sformatf(" rd_byte exp %02h got %02h", e.rd_byte, g.rd_byte)};
    if (e.wr_taken !== g.wr_taken)
      s = {s, $sformatf(" wr_taken exp %0b got %0b", e.wr_taken, g.wr_taken)};
    if (e.done_res !== g.done_res)
      s = {s, $sformatf(" done_res exp %0b got %0b", e.done_res, g.done_res)};
    if (e.media_ok !== g.media_ok)
      s = {s, $sformatf(" media_ok exp %0b got %0b", e.media_ok, g.media_ok)};
    if (e.rejected !== g.rejected)
      s = {s, $sformatf(" rejected exp %0b got %0b", e.rejected, g.rejected)};
    return s;
  endfunction

  task automatic note_failure(string msg);
    fails++;
    if (fails <= 10) $display("[%0t] mismatch:%s", $realtime, msg);
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    res_t  got;
    res_t  want;
    string diffs;
    if (!rst_ni) begin
      cur_op = OP_IDLE;
      cur_phase = PH_LOAD;
      xfer_idx = '0;
      page_sector = '0;
      expected_q.delete();
      fails = 0;
      results = 0;
      data_bytes = 0;
      rejects = 0;
    end else begin
      // retire the oldest expectation before adding the one for this edge's item
      if (out_valid_i && out_ready_i) begin
        got = {tx_valid_i, tx_byte_i, frame_first_i, rd_valid_i, rd_byte_i,
               wr_taken_i, done_res_i, media_ok_i, rejected_i};
        results++;
        if (got.rd_valid || got.wr_taken) data_bytes++;
        if (got.rejected) rejects++;
        if (expected_q.size() == 0) begin
          note_failure(" result arrived with no item outstanding");
        end else begin
          want = expected_q.pop_front();
          diffs = field_diffs(want, got);
          if (diffs != "") note_failure(diffs);
        end
      end
      if (in_valid_i && in_ready_i)
        expected_q.push_back(next_exchange(cmd_i, sector_i, rx_byte_i, wr_byte_i));
    end
    errors_o <= fails;
    pending_o <= expected_q.size();
    results_o <= results;
    data_bytes_o <= data_bytes;
    rejects_o <= rejects;
  end

endmodule

// ===== sim/dataflash_sector_sequencer_tb.sv =====
// Top of the sector sequencer testbench: clock, reset, item stimulus and the verdict.
// Instantiates dataflash_sector_sequencer and dataflash_sector_checker; uses dss_pkg.
module dataflash_sector_sequencer_tb import dss_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int ITEM_BUDGET = 1050;
  localparam int CYCLE_LIMIT = 200000;
  localparam int HOLD_CYCLES = 300;
  localparam int HOLD_AT     = 750;
  localparam logic [2:0] CMD_BAD_LO = 3'd5;
  localparam logic [2:0] CMD_BAD_HI = 3'd7;
  localparam logic [SectorW-1:0] SECTOR_LAST = SectorW'(SECTOR_COUNT - 1);

  logic               clk = 1'b0;
  logic               rst_n = 1'b0;
  logic               in_valid = 1'b0;
  logic               in_ready;
  logic [2:0]         cmd = CMD_XFER;
  logic [SectorW-1:0] sector = '0;
  logic [7:0]         rx_byte = 8'h00;
  logic [7:0]         wr_byte = 8'h00;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic               tx_valid;
  logic [7:0]         tx_byte;
  logic               frame_first;
  logic               rd_valid;
  logic [7:0]         rd_byte;
  logic               wr_taken;
  logic               done_res;
  logic               media_ok;
  logic               rejected;

  int errors;
  int pending;
  int results;
  int data_bytes;
  int rejects;

  int counted;
  int ignored;
  int send_idle = 23;
  int recv_idle = 82;
  int n_reads;
  int n_writes;
  int n_media;
  int n_waits;
  int cycles;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  dataflash_sector_sequencer uut (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_o   (in_ready),
    .cmd_i        (cmd),
    .sector_i     (sector),
    .rx_byte_i    (rx_byte),
    .wr_byte_i    (wr_byte),
    .out_valid_o  (out_valid),
    .out_ready_i  (out_ready),
    .tx_valid_o   (tx_valid),
    .tx_byte_o    (tx_byte),
    .frame_first_o(frame_first),
    .rd_valid_o   (rd_valid),
    .rd_byte_o    (rd_byte),
    .wr_taken_o   (wr_taken),
    .done_res_o   (done_res),
    .media_ok_o   (media_ok),
    .rejected_o   (rejected)
  );

  dataflash_sector_checker checker_i (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .in_valid_i   (in_valid),
    .in_ready_i   (in_ready),
    .cmd_i        (cmd),
    .sector_i     (sector),
    .rx_byte_i    (rx_byte),
    .wr_byte_i    (wr_byte),
    .out_valid_i  (out_valid),
    .out_ready_i  (out_ready),
    .tx_valid_i   (tx_valid),
    .tx_byte_i    (tx_byte),
    .frame_first_i(frame_first),
    .rd_valid_i   (rd_valid),
    .rd_byte_i    (rd_byte),
    .wr_taken_i   (wr_taken),
    .done_res_i   (done_res),
    .media_ok_i   (media_ok),
    .rejected_i   (rejected),
    .errors_o     (errors),
    .pending_o    (pending),
    .results_o    (results),
    .data_bytes_o (data_bytes),
    .rejects_o    (rejects)
  );

  // Receiver: random stalls by phase, plus one long hold-off to back the block up
  always @(posedge clk) begin
    static int  hold_left = 0;
    static bit  hold_used = 1'b0;
    if (!hold_used && counted >= HOLD_AT) begin
      hold_used = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results outstanding", cycles, pending);
      $display("simulation failed");
      $finish;
    end
  end

  // Hold valid and payload until the item is taken; gaps only before an item
  task automatic offer(logic [2:0] c, logic [SectorW-1:0] s, logic [7:0] rx, logic [7:0] wr);
    while ($urandom_range(99) < send_idle) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    cmd <= c;
    sector <= s;
    rx_byte <= rx;
    wr_byte <= wr;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  task automatic send_counted(logic [2:0] c, logic [SectorW-1:0] s, logic [7:0] rx);
    offer(c, s, rx, 8'($urandom));
    counted++;
    if (counted >= 700) begin
      send_idle = 0;
      recv_idle = 0;
    end else if (counted >= 350) begin
      send_idle = 82;
      recv_idle = 23;
    end
  endtask

  // Drop in an ignored item now and then: a start while busy, a report while idle,
  // or an undefined command code
  task automatic maybe_noise(bit busy, int pct);
    logic [2:0] c;
    if ($urandom_range(99) < pct) begin
      if ($urandom_range(1)) c = 3'($urandom_range(CMD_BAD_LO, CMD_BAD_HI));
      else if (busy) c = 3'($urandom_range(CMD_READ, CMD_WAIT));
      else c = CMD_XFER;
      offer(c, SectorW'($urandom), 8'($urandom), 8'($urandom));
      ignored++;
    end
  endtask

  task automatic xfer(logic [7:0] rx);
    maybe_noise(1'b1, 4);
    send_counted(CMD_XFER, SectorW'($urandom), rx);
  endtask

  task automatic xfer_run(int n);
    repeat (n) xfer(8'($urandom));
  endtask

  task automatic poll_status();
    bit ready;
    do begin
      ready = ($urandom_range(99) < 65);
      xfer(8'($urandom));
      xfer({ready, 7'($urandom)});
    end while (!ready);
  endtask

  task automatic run_read(logic [SectorW-1:0] s);
    send_counted(CMD_READ, s, 8'($urandom));
    xfer_run(4);
    poll_status();
    xfer_run(5 + SECTOR_BYTES);
    n_reads++;
  endtask

  task automatic run_write(logic [SectorW-1:0] s);
    send_counted(CMD_WRITE, s, 8'($urandom));
    xfer_run(4);
    poll_status();
    xfer_run(4);
    poll_status();
    xfer_run(4 + SECTOR_BYTES);
    xfer_run(4);
    poll_status();
    n_writes++;
  endtask

  task automatic run_media(logic [7:0] status);
    send_counted(CMD_MEDIA, SectorW'($urandom), 8'($urandom));
    xfer(8'($urandom));
    xfer(status);
    n_media++;
  endtask

  task automatic run_wait();
    send_counted(CMD_WAIT, SectorW'($urandom), 8'($urandom));
    poll_status();
    n_waits++;
  endtask

  initial begin
    int  pick;
    bit  read_done;
    bit  write_done;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: ignored items while idle, every undefined code
    offer(CMD_XFER, '0, 8'hFF, 8'h00);
    for (int c = CMD_BAD_LO; c <= CMD_BAD_HI; c++)
      offer(3'(c), SECTOR_LAST, 8'h00, 8'hFF);
    ignored += 4;
    // media check with starts offered while busy
    send_counted(CMD_MEDIA, SECTOR_LAST, 8'h00);
    offer(CMD_WRITE, SECTOR_LAST, 8'h00, 8'h00);
    offer(CMD_WAIT, '0, 8'hFF, 8'hFF);
    ignored += 2;
    xfer(8'h00);
    xfer(MEDIA_PAT);
    n_media++;
    // masked status bit must not matter; a mismatching pattern
    run_media(MEDIA_PAT | 8'h40);
    run_media(8'h43);
    // wait-until-idle: one busy status, then ready
    send_counted(CMD_WAIT, '0, 8'h00);
    xfer(8'hFF);
    xfer(8'h7F);
    xfer(8'h00);
    xfer(8'h80);
    n_waits++;

    read_done = 1'b0;
    write_done = 1'b0;
    while (counted < ITEM_BUDGET) begin
      pick = $urandom_range(99);
      if (!read_done && counted >= 20) begin
        read_done = 1'b1;
        run_read(SECTOR_LAST);
      end else if (!write_done && counted >= 400) begin
        write_done = 1'b1;
        run_write('0);
      end else if (pick < 45) begin
        if ($urandom_range(1)) run_media(MEDIA_PAT | {1'b0, 1'($urandom), 6'b0});
        else run_media(8'($urandom));
      end else if (pick < 85) begin
        run_wait();
      end else begin
        maybe_noise(1'b0, 100);
      end
    end
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (8) @(posedge clk);

    $display("%0d items sent (%0d ignored): %0d sector reads, %0d sector writes, "
             , counted + ignored, ignored, n_reads, n_writes);
    $display("%0d media checks, %0d idle waits; %0d results, %0d data bytes, %0d rejected",
             n_media, n_waits, results, data_bytes, rejects);
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
